// ===== rtl/uer_pkg.sv =====
// ----------------------------------------------------------------------------
// uer_pkg
// Types and constants shared by the echo ranger modules.
// ----------------------------------------------------------------------------
package uer_pkg;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned SCALE_W    = 20;
  localparam int unsigned DIST_W     = 14;
  localparam int unsigned SCALE_SHIFT = 24;
  localparam int unsigned PROD_W     = TIME_W + SCALE_W;

  localparam logic [CFG_IDX_W-1:0] REG_TICK_SCALE     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_THRESHOLD = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CHANGE     = 8'd3;

  localparam logic [SCALE_W-1:0] TICK_SCALE_RST     = 20'd57852;
  localparam logic [TIME_W-1:0]  TIMEOUT_TICKS_RST  = 32'd2800000;
  localparam logic [DIST_W-1:0]  NEAR_THRESHOLD_RST = 14'd480;
  localparam logic [DIST_W-1:0]  MIN_CHANGE_RST     = 14'd16;

  localparam logic [DIST_W-1:0]  DIST_MAX = '1;

  typedef struct packed {
    logic [SCALE_W-1:0] tick_scale;
    logic [TIME_W-1:0]  timeout_ticks;
    logic [DIST_W-1:0]  near_threshold;
    logic [DIST_W-1:0]  min_change;
  } uer_cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] pulse_ticks;
    logic              in_range;
    logic [DIST_W-1:0] distance_q4;
    logic              object_detected;
  } uer_result_t;

endpackage

// ===== rtl/ultrasonic_echo_ranger_core.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_core
// Echo pulse ranger: rising edges mark the start time, falling edges
// produce pulse width, distance in 1/16 cm and a near-object flag.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | edge_rising, capture_time
//   out_    | output    | out_valid/out_stall| pulse_ticks, in_range,
//           |           |                    | distance_q4, object_detected
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_wdata
//
// One transfer per cycle sustained while the output is not stalled.
// A result passes through the input register and the result register.
// The single 32x20 multiply sits between those two registers.
// Reset restores register defaults and clears start time and last detection.
// A stalled result holds; the input register still fills behind it.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_core (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_edge_rising,
  input  logic [uer_pkg::TIME_W-1:0]      in_capture_time,

  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [uer_pkg::TIME_W-1:0]      out_pulse_ticks,
  output logic                            out_in_range,
  output logic [uer_pkg::DIST_W-1:0]      out_distance_q4,
  output logic                            out_object_detected,

  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [uer_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  uer_pkg::uer_cfg_t    cfg;
  uer_pkg::uer_result_t res;

  logic                        s1_valid_r;
  logic                        s1_valid_nxt;
  logic                        s1_rising_r;
  logic [uer_pkg::TIME_W-1:0]  s1_time_r;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  uer_pkg::uer_result_t        out_res_r;

  logic advance;
  logic s1_fire;
  logic in_xfer;
  logic res_load;

  assign cfg_ready = 1'b1;

  uer_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  uer_range_unit u_range_unit (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .item_fire   (s1_fire),
    .item_rising (s1_rising_r),
    .item_time   (s1_time_r),
    .res         (res)
  );

  always_comb begin
    advance       = !out_valid_r || !out_stall;
    s1_fire       = s1_valid_r && (s1_rising_r || advance);
    res_load      = s1_fire && !s1_rising_r;
    in_stall      = s1_valid_r && !s1_fire;
    in_xfer       = in_valid && !in_stall;
    s1_valid_nxt  = in_xfer || (s1_valid_r && !s1_fire);
    out_valid_nxt = res_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_rising_r <= in_edge_rising;
      s1_time_r   <= in_capture_time;
    end
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pulse_ticks     = out_res_r.pulse_ticks;
  assign out_in_range        = out_res_r.in_range;
  assign out_distance_q4     = out_res_r.distance_q4;
  assign out_object_detected = out_res_r.object_detected;

endmodule

// ===== rtl/uer_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// uer_cfg_regs
// Configuration register file; writes past the last index are dropped.
// ----------------------------------------------------------------------------
module uer_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [uer_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0]    wr_data,
  output uer_pkg::uer_cfg_t                 cfg
);

  uer_pkg::uer_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_scale     <= uer_pkg::TICK_SCALE_RST;
      cfg_r.timeout_ticks  <= uer_pkg::TIMEOUT_TICKS_RST;
      cfg_r.near_threshold <= uer_pkg::NEAR_THRESHOLD_RST;
      cfg_r.min_change     <= uer_pkg::MIN_CHANGE_RST;
    end else if (wr_en) begin
      case (wr_index)
        uer_pkg::REG_TICK_SCALE: begin
          cfg_r.tick_scale <= wr_data[uer_pkg::SCALE_W-1:0];
        end
        uer_pkg::REG_TIMEOUT_TICKS: begin
          cfg_r.timeout_ticks <= wr_data[uer_pkg::TIME_W-1:0];
        end
        uer_pkg::REG_NEAR_THRESHOLD: begin
          cfg_r.near_threshold <= wr_data[uer_pkg::DIST_W-1:0];
        end
        uer_pkg::REG_MIN_CHANGE: begin
          cfg_r.min_change <= wr_data[uer_pkg::DIST_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/uer_range_unit.sv =====
// ----------------------------------------------------------------------------
// uer_range_unit
// Pulse width, timeout check, distance scaling and detection, with the
// echo start time and last detected distance held here.
// ----------------------------------------------------------------------------
module uer_range_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  uer_pkg::uer_cfg_t              cfg,
  input  logic                           item_fire,
  input  logic                           item_rising,
  input  logic [uer_pkg::TIME_W-1:0]     item_time,
  output uer_pkg::uer_result_t           res
);

  logic [uer_pkg::TIME_W-1:0]  echo_start_r;
  logic [uer_pkg::DIST_W-1:0]  last_det_r;

  logic [uer_pkg::TIME_W-1:0]  pulse;
  logic                        ok;
  logic [uer_pkg::PROD_W-1:0]  prod;
  logic [uer_pkg::PROD_W-uer_pkg::SCALE_SHIFT-1:0] scaled;
  logic [uer_pkg::DIST_W-1:0]  dist_sat;
  logic [uer_pkg::DIST_W-1:0]  dist_q4;
  logic [uer_pkg::DIST_W-1:0]  diff;
  logic                        det;

  always_comb begin
    pulse  = item_time - echo_start_r;
    ok     = (pulse <= cfg.timeout_ticks);
    prod   = {{uer_pkg::SCALE_W{1'b0}}, pulse} *
             {{uer_pkg::TIME_W{1'b0}}, cfg.tick_scale};
    scaled = prod[uer_pkg::PROD_W-1:uer_pkg::SCALE_SHIFT];
    if (|scaled[uer_pkg::PROD_W-uer_pkg::SCALE_SHIFT-1:uer_pkg::DIST_W]) begin
      dist_sat = uer_pkg::DIST_MAX;
    end else begin
      dist_sat = scaled[uer_pkg::DIST_W-1:0];
    end
    dist_q4 = ok ? dist_sat : '0;
    diff = (dist_q4 > last_det_r) ? (dist_q4 - last_det_r) : (last_det_r - dist_q4);
    det  = ok && (dist_q4 != '0) && (dist_q4 < cfg.near_threshold) &&
           (diff > cfg.min_change);

    res.pulse_ticks     = pulse;
    res.in_range        = ok;
    res.distance_q4     = dist_q4;
    res.object_detected = det;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_start_r <= '0;
      last_det_r   <= '0;
    end else if (item_fire) begin
      if (item_rising) begin
        echo_start_r <= item_time;
      end else if (det) begin
        last_det_r <= dist_q4;
      end
    end
  end

endmodule

// ===== rtl/uer_checker.sv =====
// ----------------------------------------------------------------------------
// uer_checker
// Port-level checks on the echo ranger result channel.
// ----------------------------------------------------------------------------
module uer_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [uer_pkg::TIME_W-1:0]     out_pulse_ticks,
  input logic                           out_in_range,
  input logic [uer_pkg::DIST_W-1:0]     out_distance_q4,
  input logic                           out_object_detected
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pulse_ticks) &&
      $stable(out_in_range) && $stable(out_distance_q4) &&
      $stable(out_object_detected))
    else $error("result changed while stalled");

  a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_range |-> out_distance_q4 == '0 && !out_object_detected)
    else $error("out-of-range result carries distance or detection");

  a_detect_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_object_detected |-> out_in_range && out_distance_q4 != '0)
    else $error("detection without in-range nonzero distance");

  a_detect_not_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_object_detected |-> out_distance_q4 != uer_pkg::DIST_MAX)
    else $error("detection at saturated distance");

endmodule

bind ultrasonic_echo_ranger_core uer_checker u_uer_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_pulse_ticks     (out_pulse_ticks),
  .out_in_range        (out_in_range),
  .out_distance_q4     (out_distance_q4),
  .out_object_detected (out_object_detected)
);

// ===== verif/tb_ultrasonic_echo_ranger_core.sv =====
// ----------------------------------------------------------------------------
// tb_ultrasonic_echo_ranger_core
// Self-checking bench for the echo ranger. A directed table covers reset
// defaults, register extremes, timeout boundaries and wrapping pulse widths.
// Constrained-by-hand random echo sequences follow. Every falling edge is
// predicted in-bench and compared field by field against the result stream,
// under varying input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_ultrasonic_echo_ranger_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned BLOCK_ITEMS  = 84;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned MAX_REPORTS  = 40;

  localparam logic EDGE_RISE = 1'b1;
  localparam logic EDGE_FALL = 1'b0;

  localparam logic [uer_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = 8'd4;
  localparam logic [uer_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = 8'hFF;

  localparam int unsigned TX_GAP_PCT [3] = '{34, 74, 0};
  localparam int unsigned RX_STALL_PCT [3] = '{74, 34, 0};

  typedef enum logic [1:0] {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                     kind;
    logic [uer_pkg::CFG_IDX_W-1:0] reg_idx;
    logic                          rise;
    logic [31:0]                   value;
    logic                          pinned;
    uer_pkg::uer_result_t          pin;
  } dir_row_t;

  localparam uer_pkg::uer_result_t NO_RES = '0;

  localparam dir_row_t DIR_ROWS [30] = '{
    '{ROW_ITEM, 8'd0, EDGE_FALL, 32'd0,        1'b1, '{32'd0,        1'b1, 14'd0, 1'b0}},
    '{ROW_ITEM, 8'd0, EDGE_FALL, 32'hFFFFFFFF, 1'b1, '{32'hFFFFFFFF, 1'b0, 14'd0, 1'b0}},
    '{ROW_ITEM, 8'd0, EDGE_RISE, 32'd500,      1'b0, NO_RES},
    '{ROW_ITEM, 8'd0, EDGE_RISE, 32'd1000,     1'b0, NO_RES},
    '{ROW_ITEM, 8'd0, EDGE_FALL, 32'd2801000,  1'b0, NO_RES},
    '{ROW_ITEM, 8'd0, EDGE_FALL, 32'd2801001,  1'b1, '{32'd2800001,   1'b0, 14'd0, 1'b0}},
    '{ROW_ITEM, 8'd0, EDGE_RISE, 32'hFFFFFF00, 1'b0, NO_RES},
    '{ROW_ITEM, 8'd0, EDGE_FALL, 32'h00000100, 1'b0, NO_RES},
    '{ROW_ITEM, 8'd0, EDGE_RISE, 32'd5000,     1'b0, NO_RES},
    '{ROW_ITEM, 8'd0, EDGE_FALL, 32'd34000,    1'b0, NO_RES},
    '{ROW_ITEM, 8'd0, EDGE_FALL, 32'd34000,    1'b0, NO_RES},
    '{ROW_ITEM, 8'd0, EDGE_FALL, 32'd40000,    1'b0, NO_RES},
    '{ROW_ITEM, 8'd0, EDGE_FALL, 32'd37000,    1'b0, NO_RES},
    '{ROW_CFG, uer_pkg::REG_TICK_SCALE,     EDGE_FALL, 32'hFFFFFFFF, 1'b0, NO_RES},
    '{ROW_CFG, uer_pkg::REG_TIMEOUT_TICKS,  EDGE_FALL, 32'hFFFFFFFF, 1'b0, NO_RES},
    '{ROW_CFG, uer_pkg::REG_NEAR_THRESHOLD, EDGE_FALL, 32'hFFFFFFFF, 1'b0, NO_RES},
    '{ROW_CFG, uer_pkg::REG_MIN_CHANGE,     EDGE_FALL, 32'd0,        1'b0, NO_RES},
    '{ROW_ITEM, 8'd0, EDGE_RISE, 32'd0,        1'b0, NO_RES},
    '{ROW_ITEM, 8'd0, EDGE_FALL, 32'hFFFFFFFF, 1'b1, '{32'hFFFFFFFF, 1'b1, 14'h3FFF, 1'b0}},
    '{ROW_ITEM, 8'd0, EDGE_FALL, 32'd1,        1'b1, '{32'd1,        1'b1, 14'd0, 1'b0}},
    '{ROW_ITEM, 8'd0, EDGE_FALL, 32'd17,       1'b0, NO_RES},
    '{ROW_CFG, uer_pkg::REG_TICK_SCALE,     EDGE_FALL, 32'd0,        1'b0, NO_RES},
    '{ROW_CFG, uer_pkg::REG_TIMEOUT_TICKS,  EDGE_FALL, 32'd0,        1'b0, NO_RES},
    '{ROW_CFG, uer_pkg::REG_NEAR_THRESHOLD, EDGE_FALL, 32'd0,        1'b0, NO_RES},
    '{ROW_CFG, uer_pkg::REG_MIN_CHANGE,     EDGE_FALL, 32'h3FFF,     1'b0, NO_RES},
    '{ROW_CFG, REG_UNMAPPED_LO,             EDGE_FALL, 32'hA5A5A5A5, 1'b0, NO_RES},
    '{ROW_CFG, REG_UNMAPPED_HI,             EDGE_FALL, 32'hFFFFFFFF, 1'b0, NO_RES},
    '{ROW_ITEM, 8'd0, EDGE_RISE, 32'd77,       1'b0, NO_RES},
    '{ROW_ITEM, 8'd0, EDGE_FALL, 32'd77,       1'b1, '{32'd0,        1'b1, 14'd0, 1'b0}},
    '{ROW_ITEM, 8'd0, EDGE_FALL, 32'd78,       1'b1, '{32'd1,        1'b0, 14'd0, 1'b0}}
  };

  logic                             clk = 1'b0;
  logic                             rst_n;

  logic                             in_valid;
  logic                             in_stall;
  logic                             in_edge_rising;
  logic [uer_pkg::TIME_W-1:0]       in_capture_time;

  logic                             out_valid;
  logic                             out_stall;
  logic [uer_pkg::TIME_W-1:0]       out_pulse_ticks;
  logic                             out_in_range;
  logic [uer_pkg::DIST_W-1:0]       out_distance_q4;
  logic                             out_object_detected;

  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [uer_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [uer_pkg::CFG_DATA_W-1:0]   cfg_wdata;

  // pinned expectation travels with the input payload
  logic                             pin_valid;
  uer_pkg::uer_result_t             pin_value;

  uer_pkg::uer_cfg_t                shadow_cfg;
  logic [uer_pkg::TIME_W-1:0]       echo_t0;
  logic [uer_pkg::DIST_W-1:0]       last_hit;
  uer_pkg::uer_result_t             expected_echoes [$];

  int unsigned          mismatch_count = 0;
  int unsigned          cycle_count = 0;
  int unsigned          tx_gap_pct = 0;
  int unsigned          rx_stall_pct = 0;
  bit                   tx_offering = 1'b0;
  bit                   cfg_offering = 1'b0;
  bit                   hold_req = 1'b0;

  ultrasonic_echo_ranger_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_edge_rising      (in_edge_rising),
    .in_capture_time     (in_capture_time),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_pulse_ticks     (out_pulse_ticks),
    .out_in_range        (out_in_range),
    .out_distance_q4     (out_distance_q4),
    .out_object_detected (out_object_detected),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
  endtask

  function automatic void range_echo(input logic rise,
                                     input logic [uer_pkg::TIME_W-1:0] stamp,
                                     input logic pin_on,
                                     input uer_pkg::uer_result_t pin_res);
    logic [uer_pkg::PROD_W-1:0]                      prod;
    logic [uer_pkg::PROD_W-uer_pkg::SCALE_SHIFT-1:0] whole;
    logic [uer_pkg::DIST_W-1:0]                      moved;
    uer_pkg::uer_result_t                            r;
    if (rise) begin
      echo_t0 = stamp;
      return;
    end
    r = '0;
    r.pulse_ticks = stamp - echo_t0;
    r.in_range = (r.pulse_ticks <= shadow_cfg.timeout_ticks);
    if (r.in_range) begin
      prod = uer_pkg::PROD_W'(r.pulse_ticks) * uer_pkg::PROD_W'(shadow_cfg.tick_scale);
      whole = prod[uer_pkg::PROD_W-1:uer_pkg::SCALE_SHIFT];
      r.distance_q4 = (whole > uer_pkg::DIST_MAX) ? uer_pkg::DIST_MAX
                                                  : whole[uer_pkg::DIST_W-1:0];
      moved = (r.distance_q4 > last_hit) ? r.distance_q4 - last_hit
                                         : last_hit - r.distance_q4;
      if (r.distance_q4 != '0 && r.distance_q4 < shadow_cfg.near_threshold &&
          moved > shadow_cfg.min_change) begin
        r.object_detected = 1'b1;
        last_hit = r.distance_q4;
      end
    end
    expected_echoes.push_back(pin_on ? pin_res : r);
  endfunction

  always @(posedge clk) begin : echo_check
    uer_pkg::uer_result_t got;
    uer_pkg::uer_result_t want;
    if (!rst_n) begin
      shadow_cfg = '{tick_scale: uer_pkg::TICK_SCALE_RST,
                     timeout_ticks: uer_pkg::TIMEOUT_TICKS_RST,
                     near_threshold: uer_pkg::NEAR_THRESHOLD_RST,
                     min_change: uer_pkg::MIN_CHANGE_RST};
      echo_t0 = '0;
      last_hit = '0;
      expected_echoes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          uer_pkg::REG_TICK_SCALE:
            shadow_cfg.tick_scale = cfg_wdata[uer_pkg::SCALE_W-1:0];
          uer_pkg::REG_TIMEOUT_TICKS:
            shadow_cfg.timeout_ticks = cfg_wdata[uer_pkg::TIME_W-1:0];
          uer_pkg::REG_NEAR_THRESHOLD:
            shadow_cfg.near_threshold = cfg_wdata[uer_pkg::DIST_W-1:0];
          uer_pkg::REG_MIN_CHANGE:
            shadow_cfg.min_change = cfg_wdata[uer_pkg::DIST_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        range_echo(in_edge_rising, in_capture_time, pin_valid, pin_value);
      end
      if (out_valid && !out_stall) begin
        got = '{out_pulse_ticks, out_in_range, out_distance_q4, out_object_detected};
        if (expected_echoes.size() == 0) begin
          report_mismatch("result with nothing pending", got.pulse_ticks, '0);
        end else begin
          want = expected_echoes.pop_front();
          if (got.pulse_ticks !== want.pulse_ticks)
            report_mismatch("pulse_ticks", got.pulse_ticks, want.pulse_ticks);
          if (got.in_range !== want.in_range)
            report_mismatch("in_range", 32'(got.in_range), 32'(want.in_range));
          if (got.distance_q4 !== want.distance_q4)
            report_mismatch("distance_q4", 32'(got.distance_q4), 32'(want.distance_q4));
          if (got.object_detected !== want.object_detected)
            report_mismatch("object_detected", 32'(got.object_detected),
                            32'(want.object_detected));
        end
      end
    end
  end

  initial begin : result_sink
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  task automatic end_cfg();
    if (cfg_offering) begin
      cfg_valid <= 1'b0;
      cfg_offering = 1'b0;
    end
  endtask

  task automatic push_edge(input logic rise, input logic [uer_pkg::TIME_W-1:0] stamp,
                           input logic pin_on, input uer_pkg::uer_result_t pin_res);
    end_cfg();
    in_valid        <= 1'b1;
    in_edge_rising  <= rise;
    in_capture_time <= stamp;
    pin_valid       <= pin_on;
    pin_value       <= pin_res;
    tx_offering = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    while ($urandom_range(99) < tx_gap_pct) begin
      if (tx_offering) begin
        in_valid <= 1'b0;
        tx_offering = 1'b0;
      end
      @(posedge clk);
    end
  endtask

  // quiet the input side and let every pending result out of the block
  task automatic drain();
    end_cfg();
    if (tx_offering) begin
      in_valid <= 1'b0;
      tx_offering = 1'b0;
    end
    do @(posedge clk); while (expected_echoes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [uer_pkg::CFG_IDX_W-1:0] idx,
                           input logic [uer_pkg::CFG_DATA_W-1:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    cfg_offering = 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  initial begin : stimulus
    logic [31:0]                 scale_w;
    logic [31:0]                 timeout_w;
    logic [31:0]                 thr_w;
    logic [31:0]                 minch_w;
    logic [uer_pkg::SCALE_W-1:0] cur_scale;
    logic [uer_pkg::TIME_W-1:0]  cur_timeout;
    logic [uer_pkg::DIST_W-1:0]  cur_thr;
    logic [uer_pkg::TIME_W-1:0]  start;
    logic [uer_pkg::TIME_W-1:0]  pulse;
    longint unsigned             span;
    int unsigned                 target;
    int unsigned                 sent;
    int unsigned                 falls;

    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_edge_rising  <= 1'b0;
    in_capture_time <= '0;
    pin_valid       <= 1'b0;
    pin_value       <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= '0;
    cfg_wdata       <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_gap_pct   = TX_GAP_PCT[0];
    rx_stall_pct = RX_STALL_PCT[0];
    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].kind == ROW_CFG) begin
        write_reg(DIR_ROWS[i].reg_idx, DIR_ROWS[i].value);
      end else begin
        push_edge(DIR_ROWS[i].rise, DIR_ROWS[i].value, DIR_ROWS[i].pinned, DIR_ROWS[i].pin);
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      for (int blk = 0; blk < 4; blk++) begin
        case ($urandom_range(3))
          0: scale_w = 32'(uer_pkg::TICK_SCALE_RST);
          1: scale_w = $urandom;
          2: scale_w = $urandom_range(1, 4000);
          default: scale_w = $urandom_range(0, 32'hFFFFF);
        endcase
        case ($urandom_range(2))
          0: timeout_w = $urandom;
          1: timeout_w = 32'hFFFFFFFF;
          default: timeout_w = $urandom_range(1000, 5000000);
        endcase
        case ($urandom_range(2))
          0: thr_w = $urandom_range(0, 32'h3FFF);
          1: thr_w = $urandom;
          default: thr_w = $urandom_range(50, 2000);
        endcase
        case ($urandom_range(2))
          0: minch_w = $urandom_range(0, 40);
          1: minch_w = $urandom;
          default: minch_w = 32'd0;
        endcase
        write_reg(uer_pkg::REG_TICK_SCALE, scale_w);
        write_reg(uer_pkg::REG_TIMEOUT_TICKS, timeout_w);
        write_reg(uer_pkg::REG_NEAR_THRESHOLD, thr_w);
        write_reg(uer_pkg::REG_MIN_CHANGE, minch_w);
        if ($urandom_range(3) == 0) begin
          write_reg(uer_pkg::CFG_IDX_W'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)),
                    $urandom);
        end
        cur_scale   = scale_w[uer_pkg::SCALE_W-1:0];
        cur_timeout = timeout_w;
        cur_thr     = thr_w[uer_pkg::DIST_W-1:0];

        tx_gap_pct   = TX_GAP_PCT[mode];
        rx_stall_pct = RX_STALL_PCT[mode];
        if (mode == 2 && blk == 0) begin
          hold_req = 1'b1;
        end

        sent = 0;
        while (sent < BLOCK_ITEMS) begin
          if ($urandom_range(99) < 75) begin
            start = $urandom;
            push_edge(EDGE_RISE, start, 1'b0, NO_RES);
            sent++;
            falls = $urandom_range(1, 3);
            repeat (falls) begin
              case ($urandom_range(9))
                0, 1: pulse = cur_timeout + $urandom_range(0, 4) - 2;
                2, 3: pulse = $urandom;
                default: begin
                  target = $urandom_range(0, cur_thr + cur_thr / 2 + 4);
                  if (cur_scale == '0) begin
                    pulse = $urandom_range(0, 32'hFFFFF);
                  end else begin
                    span = ((longint'(target) << uer_pkg::SCALE_SHIFT) + cur_scale - 1)
                           / cur_scale;
                    pulse = span[31:0] + $urandom_range(0, 2);
                  end
                end
              endcase
              push_edge(EDGE_FALL, start + pulse, 1'b0, NO_RES);
              sent++;
            end
          end else begin
            push_edge(1'($urandom_range(1)), $urandom, 1'b0, NO_RES);
            sent++;
          end
        end
      end
    end

    drain();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
